>>> hdl/grwc_pkg.sv
// ----------------------------------------------------------------------------
// grwc_pkg
// Shared types and constants of the grid random walk carver.
// ----------------------------------------------------------------------------
package grwc_pkg;

  localparam int unsigned GridCols     = 32;
  localparam int unsigned GridRows     = 32;
  localparam int unsigned Stride       = 2;
  localparam int unsigned DefaultStart = 5;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_READ    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_PCOL = 2'd0,
    DIR_PROW = 2'd1,
    DIR_NCOL = 2'd2,
    DIR_NROW = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    STAT_CARVED     = 3'd0,
    STAT_EDGE       = 3'd1,
    STAT_VISITED    = 3'd2,
    STAT_DISALLOWED = 3'd3,
    STAT_STUCK      = 3'd4,
    STAT_RESTARTED  = 3'd5,
    STAT_READ       = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_CARVE,
    ST_START,
    ST_FINISH
  } state_e;

  localparam int unsigned CfgStartCol = 0;
  localparam int unsigned CfgStartRow = 1;

endpackage

>>> hdl/grid_random_walk_carver.sv
// A rejected step (stuck, disallowed, edge) goes from EXEC to FINISH; a read inside the grid or a
// visited step first checks the cell in CHECK; a carving step then carves STRIDE cells in CARVE.
// A restart sweeps the grid memory one cell per cycle, then carves the start cell.
// One request at a time: the next can be taken in the cycle after the result loads.
// After reset the same sweep clears all GRID_COLS*GRID_ROWS cells (1024 by default) of the grid
// while requests are held off; the walker sits at column 5, row 5, nothing carved.
// ----------------------------------------------------------------------------
// grid_random_walk_carver
// Walker that carves a bitmap grid STRIDE cells at a time (two by default), with restart and
// cell read commands and an APB register port for the start position.
// ----------------------------------------------------------------------------
module grid_random_walk_carver
  import grwc_pkg::*;
#(
  parameter int unsigned GRID_COLS = GridCols,
  parameter int unsigned GRID_ROWS = GridRows,
  parameter int unsigned STRIDE    = Stride
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [1:0]  direction_i,
  input  logic [4:0]  query_col_i,
  input  logic [4:0]  query_row_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [4:0]  walker_col_o,
  output logic [4:0]  walker_row_o,
  output logic [3:0]  allowed_mask_o,
  output logic        cell_carved_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned Cells = GRID_COLS * GRID_ROWS;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned CW    = $clog2(GRID_COLS);
  localparam int unsigned RW    = $clog2(GRID_ROWS);
  localparam int unsigned CW1   = CW + 1;
  localparam int unsigned RW1   = RW + 1;
  localparam int unsigned QCW   = ((CW > 5) ? CW : 5) + 1;
  localparam int unsigned QRW   = ((RW > 5) ? RW : 5) + 1;
  localparam int unsigned SCW   = (STRIDE > 1) ? $clog2(STRIDE) : 1;
  localparam int unsigned ColHi = GRID_COLS - 2;
  localparam int unsigned RowHi = GRID_ROWS - 2;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c, input logic [RW-1:0] r);
    return AW'(c) * AW'(GRID_ROWS) + AW'(r);
  endfunction

  // grid memory, one bit per cell
  logic          mem [Cells];
  logic          mem_rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  state_e        st_q, st_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic          restart_q, restart_d;
  logic [CW-1:0] wx_q, wx_d;
  logic [RW-1:0] wy_q, wy_d;
  logic [3:0]    blocked_q, blocked_d;
  logic [4:0]    start_col_q, start_row_q;
  logic          out_valid_q, out_valid_d;
  logic          load_out;

  cmd_e          cmd_q;
  dir_e          dir_q;
  logic [4:0]    qcol_q, qrow_q;
  status_e       res_status_q, res_status_d;
  logic          res_carved_q, res_carved_d;
  logic [SCW-1:0] cnt_q, cnt_d;
  logic [2:0]    out_status_q;
  logic [4:0]    out_col_q, out_row_q;
  logic [3:0]    out_mask_q;
  logic          out_carved_q;

  logic          in_acc, cfg_wr;
  logic [CW1-1:0] nx_ext;
  logic [RW1-1:0] ny_ext;
  logic          tgt_in_border;
  logic [CW-1:0] wx_step, sx;
  logic [RW-1:0] wy_step, sy;
  logic          step_in_grid;
  logic          q_in_grid;
  logic [3:0]    dir_bit;
  logic [CW+4:0] wx_wide;
  logic [RW+4:0] wy_wide;

  assign in_acc = in_valid_i && !in_stall_o;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {27'b0, start_row_q} : {27'b0, start_col_q};

  assign in_stall_o     = (st_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign walker_col_o   = out_col_q;
  assign walker_row_o   = out_row_q;
  assign allowed_mask_o = out_mask_q;
  assign cell_carved_o  = out_carved_q;

  // far target of a step; a wrapped negative lands above the border
  always_comb begin
    nx_ext  = {1'b0, wx_q};
    ny_ext  = {1'b0, wy_q};
    wx_step = wx_q;
    wy_step = wy_q;
    case (dir_q)
      DIR_PCOL: begin
        nx_ext  = {1'b0, wx_q} + CW1'(STRIDE);
        wx_step = wx_q + CW'(1);
      end
      DIR_PROW: begin
        ny_ext  = {1'b0, wy_q} + RW1'(STRIDE);
        wy_step = wy_q + RW'(1);
      end
      DIR_NCOL: begin
        nx_ext  = {1'b0, wx_q} - CW1'(STRIDE);
        wx_step = wx_q - CW'(1);
      end
      default: begin
        ny_ext  = {1'b0, wy_q} - RW1'(STRIDE);
        wy_step = wy_q - RW'(1);
      end
    endcase
  end

  assign dir_bit       = 4'b0001 << dir_q;
  assign tgt_in_border = (nx_ext >= CW1'(1)) && (nx_ext <= CW1'(ColHi)) &&
                         (ny_ext >= RW1'(1)) && (ny_ext <= RW1'(RowHi));
  assign step_in_grid  = ({1'b0, wx_step} < CW1'(GRID_COLS)) &&
                         ({1'b0, wy_step} < RW1'(GRID_ROWS));
  assign q_in_grid     = (QCW'(qcol_q) < QCW'(GRID_COLS)) && (QRW'(qrow_q) < QRW'(GRID_ROWS));

  // start position saturated into the inner border
  always_comb begin
    if (QCW'(start_col_q) > QCW'(ColHi)) begin
      sx = CW'(ColHi);
    end else if (start_col_q == 5'd0) begin
      sx = CW'(1);
    end else begin
      sx = CW'(start_col_q);
    end
    if (QRW'(start_row_q) > QRW'(RowHi)) begin
      sy = RW'(RowHi);
    end else if (start_row_q == 5'd0) begin
      sy = RW'(1);
    end else begin
      sy = RW'(start_row_q);
    end
  end

  assign wx_wide = {5'b0, wx_q};
  assign wy_wide = {5'b0, wy_q};

  always_comb begin
    st_d         = st_q;
    clr_addr_d   = clr_addr_q;
    restart_d    = restart_q;
    wx_d         = wx_q;
    wy_d         = wy_q;
    blocked_d    = blocked_q;
    res_status_d = res_status_q;
    res_carved_d = res_carved_q;
    cnt_d        = cnt_q;
    mem_we       = 1'b0;
    mem_waddr    = clr_addr_q;
    mem_wdata    = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    load_out     = 1'b0;
    unique case (st_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(Cells - 1)) begin
          clr_addr_d = '0;
          st_d       = restart_q ? ST_START : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          st_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_carved_d = 1'b0;
        unique case (cmd_q)
          CMD_RESTART: begin
            restart_d  = 1'b1;
            clr_addr_d = '0;
            st_d       = ST_CLEAR;
          end
          CMD_STEP: begin
            if (blocked_q == 4'hF) begin
              res_status_d = STAT_STUCK;
              st_d         = ST_FINISH;
            end else if ((blocked_q & dir_bit) != 4'b0) begin
              res_status_d = STAT_DISALLOWED;
              st_d         = ST_FINISH;
            end else if (!tgt_in_border) begin
              blocked_d    = blocked_q | dir_bit;
              res_status_d = STAT_EDGE;
              st_d         = ST_FINISH;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = cell_addr(nx_ext[CW-1:0], ny_ext[RW-1:0]);
              st_d      = ST_CHECK;
            end
          end
          default: begin
            // code three reads as well
            res_status_d = STAT_READ;
            if (q_in_grid) begin
              mem_re    = 1'b1;
              mem_raddr = cell_addr(CW'(qcol_q), RW'(qrow_q));
              st_d      = ST_CHECK;
            end else begin
              st_d = ST_FINISH;
            end
          end
        endcase
      end
      ST_CHECK: begin
        if (cmd_q == CMD_STEP) begin
          if (mem_rd_q) begin
            blocked_d    = blocked_q | dir_bit;
            res_status_d = STAT_VISITED;
            st_d         = ST_FINISH;
          end else begin
            blocked_d    = 4'b0;
            res_status_d = STAT_CARVED;
            cnt_d        = '0;
            st_d         = ST_CARVE;
          end
        end else begin
          res_carved_d = mem_rd_q;
          st_d         = ST_FINISH;
        end
      end
      ST_CARVE: begin
        wx_d      = wx_step;
        wy_d      = wy_step;
        mem_we    = step_in_grid;
        mem_waddr = cell_addr(wx_step, wy_step);
        mem_wdata = 1'b1;
        cnt_d     = cnt_q + SCW'(1);
        if (cnt_q == SCW'(STRIDE - 1)) begin
          st_d = ST_FINISH;
        end
      end
      ST_START: begin
        wx_d         = sx;
        wy_d         = sy;
        blocked_d    = 4'b0;
        mem_we       = 1'b1;
        mem_waddr    = cell_addr(sx, sy);
        mem_wdata    = 1'b1;
        res_status_d = STAT_RESTARTED;
        restart_d    = 1'b0;
        st_d         = ST_FINISH;
      end
      ST_FINISH: begin
        // result register frees up when its current request leaves
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_addr_q  <= '0;
      restart_q   <= 1'b0;
      wx_q        <= CW'(DefaultStart);
      wy_q        <= RW'(DefaultStart);
      blocked_q   <= 4'b0;
      start_col_q <= 5'(DefaultStart);
      start_row_q <= 5'(DefaultStart);
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_addr_q  <= clr_addr_d;
      restart_q   <= restart_d;
      wx_q        <= wx_d;
      wy_q        <= wy_d;
      blocked_q   <= blocked_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        if (paddr[2] == 1'(CfgStartRow)) begin
          start_row_q <= pwdata[4:0];
        end else begin
          start_col_q <= pwdata[4:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_carved_q <= res_carved_d;
    cnt_q        <= cnt_d;
    if (in_acc) begin
      cmd_q  <= cmd_e'(cmd_i);
      dir_q  <= dir_e'(direction_i);
      qcol_q <= query_col_i;
      qrow_q <= query_row_i;
    end
    if (load_out) begin
      out_status_q <= res_status_q;
      out_col_q    <= wx_wide[4:0];
      out_row_q    <= wy_wide[4:0];
      out_mask_q   <= ~blocked_q;
      out_carved_q <= res_carved_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rd_q <= mem[mem_raddr];
    end
  end

  // a carve always ends with every direction open
  a_carve_unblocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_CARVED) |-> (allowed_mask_o == 4'hF))
    else $error("carve result with a blocked direction");

  a_walker_in_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FINISH && (res_status_q == STAT_CARVED || res_status_q == STAT_RESTARTED))
    |-> (wx_q >= CW'(1) && {1'b0, wx_q} <= CW1'(ColHi) &&
         wy_q >= RW'(1) && {1'b0, wy_q} <= RW1'(RowHi)))
    else $error("walker left the inner border");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({1'b0, mem_waddr} < (AW + 1)'(Cells)))
    else $error("grid write beyond the memory");

  a_request_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (st_q == ST_EXEC && in_stall_o))
    else $error("accepted request not taken into work");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (st_q == ST_IDLE && out_valid_o))
    else $error("result load out of sequence");

endmodule
